// File: design/ppbc_pkg.sv
// Shared constants for the ping-pong buffer controller: field widths,
// command and status codes, and the default buffer size.
// No dependencies.
`default_nettype none

package ppbc_pkg;

   // Default size of each transmit buffer in bytes.
   localparam int BUFFER_BYTES_DEFAULT = 16384;

   // Field widths of the request and response items.
   localparam int WRITE_COUNT_W = 16;
   localparam int STATUS_W      = 2;
   localparam int BYTES_W       = 15;
   localparam int LEVEL_W       = 14;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 56;

   // Request kinds carried in tuser.
   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_COMPLETE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd3;

endpackage

`default_nettype wire

// File: design/ping_pong_buffer_controller_unit.sv
// Ping-pong transmit buffer controller: fill tracking, pending flags and
// transfer launch for two buffers. Depends on ppbc_pkg.
`default_nettype none

// How to use this block:
// The request channel (req_*) carries one item per host write or transfer
// completion. req_tuser selects the kind: 0 is a host write whose byte count
// sits in req_tdata[15:0], 1 is a completion whose status bit sits in
// req_tdata[16]. Every request item produces exactly one response item on
// the rsp_* channel with the status, the bytes taken, a transfer launch
// indication (buffer index and length) and the fill state after the item.
// On acceptance the item is captured in an input register, evaluated
// against the buffer state by a single level of logic, and written to
// the response register while the state updates. Throughput is one item
// per cycle while rsp_tready stays high, since the fill position and
// pending flags that the next item reads update in the same cycle.
// When the receiver holds rsp_tready low, the response register holds its
// item and the input register keeps one more; beyond that req_tready drops.
// Reset (synchronous, active high) empties both registers, selects buffer 0
// for filling and sending, clears both pending flags and marks the transfer
// engine idle.
module ping_pong_buffer_controller_unit #(
   parameter int BUFFER_BYTES = ppbc_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   // Request channel.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [15:0] write_count, [16] transfer_ok, [23:17] zero
   input  wire  [ppbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] command
   input  wire                               req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [1:0] status, [16:2] accepted_bytes, [17] start_transfer,
   // [18] transfer_buffer, [33:19] transfer_length, [34] fill_open,
   // [48:35] fill_level, [55:49] zero
   output logic [ppbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int POS_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam int SUM_W = (CNT_W > ppbc_pkg::WRITE_COUNT_W) ? CNT_W
                                                            : ppbc_pkg::WRITE_COUNT_W;
   localparam int PAD_W = ppbc_pkg::RSP_DATA_W - (ppbc_pkg::STATUS_W
                          + 3 * 1 + 2 * ppbc_pkg::BYTES_W + ppbc_pkg::LEVEL_W);

   // Input register.
   logic                                in_valid_ff, in_valid_in;
   logic                                in_cmd_ff;
   logic [ppbc_pkg::WRITE_COUNT_W-1:0]  in_count_ff;
   logic                                in_ok_ff;

   // Buffer state.
   logic             fill_index_ff, fill_index_in;
   logic [POS_W-1:0] fill_pos_ff, fill_pos_in;
   logic [1:0]       pending_ff, pending_in;
   logic             send_index_ff, send_index_in;
   logic             running_ff, running_in;

   // Response register.
   logic                               out_valid_ff, out_valid_in;
   logic [ppbc_pkg::RSP_DATA_W-1:0]    out_data_ff, out_data_in;

   logic             advance;
   logic [SUM_W-1:0] room;
   logic [SUM_W-1:0] count_clip;
   logic [SUM_W-1:0] pos_sum;
   logic [ppbc_pkg::STATUS_W-1:0] status;
   logic [ppbc_pkg::BYTES_W-1:0]  accepted;
   logic             started;
   logic             tbuf;
   logic [ppbc_pkg::BYTES_W-1:0]  tlen;

   // The held item moves on when the response register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Room left in the fill buffer and the clipped write count.
   always_comb begin
      room       = SUM_W'(BUFFER_BYTES) - SUM_W'(fill_pos_ff);
      count_clip = (SUM_W'(in_count_ff) > room) ? room : SUM_W'(in_count_ff);
      pos_sum    = SUM_W'(fill_pos_ff) + count_clip;
   end

   // Evaluate the held item against the state.
   always_comb begin
      fill_index_in = fill_index_ff;
      fill_pos_in   = fill_pos_ff;
      pending_in    = pending_ff;
      send_index_in = send_index_ff;
      running_in    = running_ff;
      status        = ppbc_pkg::ST_OK;
      accepted      = '0;
      started       = 1'b0;
      tbuf          = 1'b0;
      tlen          = '0;

      if (in_cmd_ff == ppbc_pkg::CMD_WRITE) begin
         if (pending_ff[fill_index_ff]) begin
            status = ppbc_pkg::ST_BUSY;
         end else if (count_clip == '0) begin
            status = ppbc_pkg::ST_NOSPACE;
         end else begin
            accepted = ppbc_pkg::BYTES_W'(count_clip);
            if (pos_sum >= SUM_W'(BUFFER_BYTES)) begin
               // Buffer full: hand it to the sender and switch buffers.
               pending_in[fill_index_ff] = 1'b1;
               fill_index_in             = !fill_index_ff;
               fill_pos_in               = '0;
            end else begin
               fill_pos_in = POS_W'(pos_sum);
            end
         end
      end else begin
         if (in_ok_ff) begin
            running_in                = 1'b0;
            pending_in[send_index_ff] = 1'b0;
            send_index_in             = !send_index_ff;
         end else begin
            status = ppbc_pkg::ST_ERROR;
         end
      end

      // Launch the next pending buffer when the engine is idle.
      if (!running_in && pending_in[send_index_in]) begin
         running_in = 1'b1;
         started    = 1'b1;
         tbuf       = send_index_in;
         tlen       = ppbc_pkg::BYTES_W'(BUFFER_BYTES);
      end

      out_data_in = {PAD_W'(0),
                     ppbc_pkg::LEVEL_W'(fill_pos_in),
                     !pending_in[fill_index_in],
                     tlen, tbuf, started, accepted, status};
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         fill_index_ff <= 1'b0;
         fill_pos_ff   <= '0;
         pending_ff    <= '0;
         send_index_ff <= 1'b0;
         running_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            fill_index_ff <= fill_index_in;
            fill_pos_ff   <= fill_pos_in;
            pending_ff    <= pending_in;
            send_index_ff <= send_index_in;
            running_ff    <= running_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff   <= req_tuser;
         in_count_ff <= req_tdata[ppbc_pkg::WRITE_COUNT_W-1:0];
         in_ok_ff    <= req_tdata[ppbc_pkg::WRITE_COUNT_W];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // A running transfer always belongs to a pending buffer at the send pointer.
   assert property (@(posedge clock) disable iff (reset)
      running_ff |-> pending_ff[send_index_ff])
      else $error("transfer running without a pending buffer");

   // The fill position never reaches the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_pos_ff) < BUFFER_BYTES)
      else $error("fill position out of range");

   // Bytes are only reported as taken on an ok status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[16:2] != '0) |-> (rsp_tdata[1:0] == ppbc_pkg::ST_OK))
      else $error("bytes accepted with a failing status");

   // A launch marks the engine running.
   assert property (@(posedge clock) disable iff (reset)
      (advance && started) |=> running_ff)
      else $error("launch did not mark the engine running");

endmodule

`default_nettype wire

// File: tb/ping_pong_buffer_controller_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ping-pong buffer controller unit: drives host write
// and completion items, predicts every response from its own buffer model and compares.
// Depends on ppbc_pkg and ping_pong_buffer_controller_unit.

module ping_pong_buffer_controller_unit_tb;
   import ppbc_pkg::*;

   localparam int BUF_BYTES  = BUFFER_BYTES_DEFAULT;
   localparam int ITEM_TOTAL = 1400;
   localparam int QUIET_TAIL = 120;
   localparam int PRINT_CAP  = 100;

   // One response item, split into its fields.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  accepted;
      logic                started;
      logic                xfer_buf;
      logic [BYTES_W-1:0]  xfer_len;
      logic                fill_open;
      logic [LEVEL_W-1:0]  level;
   } buf_rsp_type;

   // Shadow of the two buffers and the transfer engine, plus the responses still due.
   class buffer_scoreboard;
      bit          fill_sel;
      int unsigned fill_pos;
      bit [1:0]    pending;
      bit          send_sel;
      bit          engine_busy;
      buf_rsp_type due_rsp[$];
      int unsigned errors;
      int unsigned rsp_seen;

      function new();
         fill_sel    = 1'b0;
         fill_pos    = 0;
         pending     = 2'b00;
         send_sel    = 1'b0;
         engine_busy = 1'b0;
         errors      = 0;
         rsp_seen    = 0;
      endfunction

      function int unsigned room_left();
         return pending[fill_sel] ? 0 : BUF_BYTES - fill_pos;
      endfunction

      function bit fill_blocked();
         return pending[fill_sel];
      endfunction

      function int unsigned outstanding();
         return due_rsp.size();
      endfunction

      // Applies one accepted item to the buffer state and queues the response it causes.
      function void note_request(logic cmd, logic [WRITE_COUNT_W-1:0] count, logic ok);
         buf_rsp_type r;
         int unsigned take;
         r = '0;
         r.status = ST_OK;
         if (cmd == CMD_WRITE) begin
            if (pending[fill_sel]) begin
               r.status = ST_BUSY;
            end else begin
               // Clip the offered count to the room left in the fill buffer.
               take = (count > BUF_BYTES - fill_pos) ? BUF_BYTES - fill_pos : count;
               if (take == 0) begin
                  r.status = ST_NOSPACE;
               end else begin
                  r.accepted = BYTES_W'(take);
                  fill_pos += take;
                  if (fill_pos >= BUF_BYTES) begin
                     pending[fill_sel] = 1'b1;
                     fill_sel = ~fill_sel;
                     fill_pos = 0;
                  end
               end
            end
         end else if (ok) begin
            // A good completion frees the buffer at the send pointer, running or not.
            engine_busy = 1'b0;
            pending[send_sel] = 1'b0;
            send_sel = ~send_sel;
         end else begin
            r.status = ST_ERROR;
         end
         // An idle engine picks up the buffer at the send pointer if it is waiting.
         if (!engine_busy && pending[send_sel]) begin
            engine_busy = 1'b1;
            r.started   = 1'b1;
            r.xfer_buf  = send_sel;
            r.xfer_len  = BYTES_W'(BUF_BYTES);
         end
         r.fill_open = ~pending[fill_sel];
         r.level     = LEVEL_W'(fill_pos);
         due_rsp.push_back(r);
      endfunction

      task report(string what, longint unsigned got_v, longint unsigned want_v);
         errors++;
         if (errors <= PRINT_CAP)
            $display("ERROR at response %0d: %s is 0x%0h, predicted 0x%0h",
                     rsp_seen, what, got_v, want_v);
      endtask

      // Compares one accepted response with the oldest prediction, field by field.
      task check_response(logic [RSP_DATA_W-1:0] data);
         buf_rsp_type got;
         buf_rsp_type want;
         got.status    = data[1:0];
         got.accepted  = data[16:2];
         got.started   = data[17];
         got.xfer_buf  = data[18];
         got.xfer_len  = data[33:19];
         got.fill_open = data[34];
         got.level     = data[48:35];
         rsp_seen++;
         if (due_rsp.size() == 0) begin
            report("response with nothing awaited, data", data, 0);
         end else begin
            want = due_rsp.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.accepted !== want.accepted)
               report("accepted_bytes", got.accepted, want.accepted);
            if (got.started !== want.started)
               report("start_transfer", got.started, want.started);
            if (got.xfer_buf !== want.xfer_buf)
               report("transfer_buffer", got.xfer_buf, want.xfer_buf);
            if (got.xfer_len !== want.xfer_len)
               report("transfer_length", got.xfer_len, want.xfer_len);
            if (got.fill_open !== want.fill_open)
               report("fill_open", got.fill_open, want.fill_open);
            if (got.level !== want.level) report("fill_level", got.level, want.level);
         end
      endtask
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   buffer_scoreboard tracker = new();
   int unsigned      req_gap_pct   = 10;
   int unsigned      rsp_stall_pct = 10;
   int unsigned      rsp_hold      = 0;
   bit               quiet         = 1'b0;

   ping_pong_buffer_controller_unit #(
      .BUFFER_BYTES(BUF_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Receiver: ready by default, with random stall bursts.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_hold   <= $urandom_range(1, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted response item is checked as it leaves the block.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   function automatic int unsigned pick_pace();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   // Offers one item, waits until it is taken, then maybe idles for a short burst.
   task automatic send_item(logic cmd, logic [WRITE_COUNT_W-1:0] count, logic ok);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - WRITE_COUNT_W - 1){1'b0}}, ok, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(cmd, count, ok);
      if (!quiet && req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Holds the sender off until every response already owed has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Picks a random item, biased toward write runs that fill buffers and
   // toward completions once filling is blocked.
   task automatic random_item();
      int unsigned              pick;
      int unsigned              room;
      logic [WRITE_COUNT_W-1:0] count;
      pick = $urandom_range(0, 99);
      room = tracker.room_left();
      if ((tracker.fill_blocked() && pick < 70) || (!tracker.fill_blocked() && pick < 12)) begin
         send_item(CMD_COMPLETE, WRITE_COUNT_W'($urandom), $urandom_range(0, 99) < 85);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40) count = WRITE_COUNT_W'($urandom_range(1, 4096));
         else if (pick < 60) count = WRITE_COUNT_W'($urandom);
         else if (pick < 75) count = WRITE_COUNT_W'(room);
         else if (pick < 85) count = WRITE_COUNT_W'(room + $urandom_range(1, 64));
         else if (pick < 90) count = '0;
         else count = WRITE_COUNT_W'($urandom_range(1, 16));
         send_item(CMD_WRITE, count, 1'($urandom_range(0, 1)));
      end
   endtask

   // Main stimulus.
   initial begin
      int unsigned n;
      int unsigned wait_cycles;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero-byte write, clipping, filling both buffers, busy refusal,
      // error completion, completions with and without a transfer running.
      send_item(CMD_WRITE, 16'd0, 1'b1);
      send_item(CMD_WRITE, 16'd1, 1'b0);
      send_item(CMD_WRITE, 16'd16382, 1'b1);
      send_item(CMD_WRITE, 16'hFFFF, 1'b0);
      send_item(CMD_WRITE, 16'hFFFF, 1'b1);
      send_item(CMD_WRITE, 16'd100, 1'b0);
      send_item(CMD_COMPLETE, 16'hFFFF, 1'b0);
      send_item(CMD_COMPLETE, 16'h0000, 1'b1);
      send_item(CMD_WRITE, 16'd16384, 1'b0);
      send_item(CMD_WRITE, 16'd5, 1'b1);
      send_item(CMD_COMPLETE, 16'h1234, 1'b1);
      send_item(CMD_COMPLETE, 16'h0000, 1'b1);
      send_item(CMD_COMPLETE, 16'hFFFF, 1'b1);
      send_item(CMD_COMPLETE, 16'h0001, 1'b0);
      send_item(CMD_WRITE, 16'h8000, 1'b0);
      send_item(CMD_WRITE, 16'h5555, 1'b1);
      send_item(CMD_WRITE, 16'hAAAA, 1'b0);
      send_item(CMD_COMPLETE, 16'h8000, 1'b1);
      send_item(CMD_COMPLETE, 16'h7FFF, 1'b1);
      send_item(CMD_WRITE, 16'd0, 1'b0);
      drain_responses();

      // Random part, with the idling pace changed every few hundred items.
      for (n = 0; n < ITEM_TOTAL; n++) begin
         if (n % 200 == 0) begin
            req_gap_pct   = pick_pace();
            rsp_stall_pct = pick_pace();
         end
         if (n == ITEM_TOTAL / 2) drain_responses();
         if (n == ITEM_TOTAL - QUIET_TAIL) quiet = 1'b1;
         random_item();
      end

      // Let the last responses come back, bounded, then wait briefly before the final check.
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      @(posedge clock);
      while (tracker.outstanding() != 0 && wait_cycles < 2000) begin
         wait_cycles++;
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (tracker.outstanding() != 0)
         tracker.report("responses never delivered, count", tracker.outstanding(), 0);

      if (tracker.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: ping_pong_buffer_controller_unit.f
design/ppbc_pkg.sv
design/ping_pong_buffer_controller_unit.sv
tb/ping_pong_buffer_controller_unit_tb.sv
